// ===== rtl/core/pidc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pidc_pkg;

  localparam int IO_W    = 32;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 3;

  // request codes carried in tuser
  localparam logic [1:0] REQ_UPDATE = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_BND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_D_MODE  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_E,
    ST_INT,
    ST_MUL_I,
    ST_DSEL,
    ST_MUL_D,
    ST_DIV,
    ST_MUL_LP,
    ST_LP,
    ST_SUM,
    ST_OSUM,
    ST_PEAK,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/pidc_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pidc_mul #(
  parameter int N = 33
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [N-1:0]   a,
  input  wire logic [N-1:0]   b,
  output logic                done,
  output logic [2*N-1:0]      prod
);
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  a_r;
  logic [CW-1:0] cnt;
  logic          run;
  logic [N:0]    sum;

  // one multiplier bit per cycle, shift-add from the low end
  assign sum = {1'b0, prod[2*N-1:N]} + {1'b0, (prod[0] ? a_r : {N{1'b0}})};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= CW'(N);
        a_r  <= a;
        prod <= {{N{1'b0}}, b};
      end else if (run) begin
        prod <= {sum, prod[N-1:1]};
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/pidc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pidc_div #(
  parameter int DW = 66,
  parameter int VW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quot
);
  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] d_r;
  logic [VW-1:0] rem;
  logic [VW:0]   r2;
  logic          ge;
  logic [CW-1:0] cnt;
  logic          run;

  // restoring division, one quotient bit per cycle
  assign r2 = {rem, quot[DW-1]};
  assign ge = r2 >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= CW'(DW);
        d_r  <= divisor;
        rem  <= '0;
        quot <= dividend;
      end else if (run) begin
        rem  <= ge ? VW'(r2 - {1'b0, d_r}) : VW'(r2);
        quot <= {quot[DW-2:0], ge};
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/pid_controller_two_d_modes_unit.sv =====
// clear, read and skipped words go straight from decode to output; an update runs
//   multiplies and, once primed, a divide; derivative on measurement adds a multiply
// throughput: one word at a time, taken in the cycle after the previous result is loaded;
//   a waiting result holds only the next result
// reset (rst, synchronous, active high) clears the integral, history, terms and peaks
//   and loads the register defaults: gains 0, both bounds at maximum, derivative on error
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_two_d_modes_unit #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // setpoint [31:0], measurement [63:32], step_time [95:64]
  input  wire logic [95:0]                  s_axis_tdata,
  // req_type [1:0]
  input  wire logic [1:0]                   s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // control_out, p_term, i_term, d_term, peak_output, peak_error, 32 bits each
  output logic [191:0]                      m_axis_tdata,
  // skipped [0]
  output logic [0:0]                        m_axis_tuser,
  input  wire logic                         cfg_we,
  input  wire logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pidc_pkg::CFG_W-1:0]   cfg_data
);
  localparam int W  = WORD_WIDTH;
  localparam int OW = (W + 1 > 32) ? W + 1 : 32;   // multiplier operand width
  localparam int PW = 2 * OW;                      // product width
  localparam int SW = PW + 2;                      // wide signed compare domain
  localparam int XW = (W > 32) ? W : 32;
  localparam logic signed [SW-1:0] WMAX_S = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] WMIN_S = -WMAX_S - SW'(1);
  localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);
  localparam int LP_COEF = ((12 << FRAC_BITS) + 50) / 100;

  // ---------------- helpers ----------------
  function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
    if (v > WMAX_S)      return W'(WMAX_S);
    else if (v < WMIN_S) return W'(WMIN_S);
    else                 return W'(v);
  endfunction

  function automatic logic signed [W-1:0] sat_mag(input logic neg, input logic [PW-1:0] m);
    logic [W-1:0] lo;
    lo = W'(m);
    if (neg) return (m >= HALF) ? W'(WMIN_S) : -lo;
    else     return (m > PW'(WMAX_S)) ? W'(WMAX_S) : lo;
  endfunction

  function automatic logic [OW-1:0] mag_w(input logic signed [W-1:0] x);
    logic [OW-1:0] e;
    e = OW'(x);
    return x[W-1] ? -e : e;
  endfunction

  function automatic logic [OW-1:0] mag_d(input logic signed [W:0] x);
    logic [OW-1:0] e;
    e = OW'(x);
    return x[W] ? -e : e;
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic signed [W-1:0] x);
    return SW'(x);
  endfunction

  function automatic logic signed [SW-1:0] abs_s(input logic signed [W-1:0] x);
    return x[W-1] ? -ext(x) : ext(x);
  endfunction

  function automatic logic signed [W-1:0] in_word(input logic signed [31:0] raw);
    return sat(SW'(raw));
  endfunction

  function automatic logic [31:0] to_io(input logic signed [W-1:0] x);
    logic signed [XW-1:0] e;
    e = XW'(x);
    return e[31:0];
  endfunction

  // ---------------- configuration ----------------
  logic [pidc_pkg::CFG_W-1:0] gain_p, gain_i, gain_d, int_bnd, out_bnd;
  logic                       d_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p  <= '0;
      gain_i  <= '0;
      gain_d  <= '0;
      int_bnd <= '1;
      out_bnd <= '1;
      d_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pidc_pkg::REG_GAIN_P:  gain_p  <= cfg_data;
        pidc_pkg::REG_GAIN_I:  gain_i  <= cfg_data;
        pidc_pkg::REG_GAIN_D:  gain_d  <= cfg_data;
        pidc_pkg::REG_INT_BND: int_bnd <= cfg_data;
        pidc_pkg::REG_OUT_BND: out_bnd <= cfg_data;
        pidc_pkg::REG_D_MODE:  d_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // bounds above the word maximum act as the maximum
  logic signed [SW-1:0] ib_s, ob_s;
  assign ib_s = (SW'(int_bnd) > WMAX_S) ? WMAX_S : SW'(int_bnd);
  assign ob_s = (SW'(out_bnd) > WMAX_S) ? WMAX_S : SW'(out_bnd);

  // ---------------- state ----------------
  pidc_pkg::state_t state, state_next;

  logic [1:0]           req_r;
  logic                 skip_r;
  logic signed [W-1:0]  sp, ms, dt, err;
  logic signed [W-1:0]  integ, last_err, last_ms, held, t_p, t_i, t_d, dlp;
  logic signed [W-1:0]  pk_o, pk_e, tmp, o_w;
  logic signed [W:0]    diff;
  logic                 dneg, mneg, primed, op_run;

  logic                 mul_start, mul_done, div_start, div_done;
  logic [OW-1:0]        mul_a, mul_b;
  logic [PW-1:0]        mul_prod, div_quot;
  logic signed [W-1:0]  mq, dq;
  logic                 out_free, dt_bad;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign dt_bad   = dt[W-1] || (dt == '0);
  assign mq = sat_mag(mneg, mul_prod >> FRAC_BITS);
  assign dq = sat_mag(dneg, div_quot);

  pidc_mul #(.N(OW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  pidc_div #(.DW(PW), .VW(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mul_prod),
    .divisor(dt), .done(div_done), .quot(div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= pidc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state, unit starts and operand selection
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state)
      pidc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = pidc_pkg::ST_DECODE;
      end
      pidc_pkg::ST_DECODE: begin
        if (req_r == pidc_pkg::REQ_UPDATE && !dt_bad) state_next = pidc_pkg::ST_ERR;
        else                                          state_next = pidc_pkg::ST_OUT;
      end
      pidc_pkg::ST_ERR: state_next = pidc_pkg::ST_MUL_P;
      pidc_pkg::ST_MUL_P: begin
        mul_a = OW'(gain_p);
        mul_b = mag_w(err);
        mul_start = !op_run;
        if (mul_done) state_next = pidc_pkg::ST_MUL_E;
      end
      pidc_pkg::ST_MUL_E: begin
        mul_a = mag_w(err);
        mul_b = mag_w(dt);
        mul_start = !op_run;
        if (mul_done) state_next = pidc_pkg::ST_INT;
      end
      pidc_pkg::ST_INT: state_next = pidc_pkg::ST_MUL_I;
      pidc_pkg::ST_MUL_I: begin
        mul_a = OW'(gain_i);
        mul_b = mag_w(integ);
        mul_start = !op_run;
        if (mul_done) state_next = pidc_pkg::ST_DSEL;
      end
      pidc_pkg::ST_DSEL: begin
        state_next = primed ? pidc_pkg::ST_MUL_D : pidc_pkg::ST_SUM;
      end
      pidc_pkg::ST_MUL_D: begin
        mul_a = OW'(gain_d);
        mul_b = mag_d(diff);
        mul_start = !op_run;
        if (mul_done) state_next = pidc_pkg::ST_DIV;
      end
      pidc_pkg::ST_DIV: begin
        div_start = !op_run;
        if (div_done) state_next = d_mode ? pidc_pkg::ST_MUL_LP : pidc_pkg::ST_SUM;
      end
      pidc_pkg::ST_MUL_LP: begin
        mul_a = OW'(LP_COEF);
        mul_b = mag_d(diff);
        mul_start = !op_run;
        if (mul_done) state_next = pidc_pkg::ST_LP;
      end
      pidc_pkg::ST_LP:   state_next = pidc_pkg::ST_SUM;
      pidc_pkg::ST_SUM:  state_next = pidc_pkg::ST_OSUM;
      pidc_pkg::ST_OSUM: state_next = pidc_pkg::ST_PEAK;
      pidc_pkg::ST_PEAK: state_next = pidc_pkg::ST_OUT;
      pidc_pkg::ST_OUT: begin
        if (out_free) state_next = pidc_pkg::ST_IDLE;
      end
      default: state_next = pidc_pkg::ST_IDLE;
    endcase
  end

  // output sum, clamped to the output bound
  logic signed [W-1:0] o_sat;
  assign o_sat = sat(ext(tmp) + ext(t_d));
  assign o_w = (ext(o_sat) > ob_s) ? W'(ob_s) :
               ((ext(o_sat) < -ob_s) ? W'(-ob_s) : o_sat);

  // integral step, clamped to the integral bound
  logic signed [W-1:0] int_sat, int_new, lp_new;
  assign int_sat = sat(ext(integ) + ext(tmp));
  assign int_new = (ext(int_sat) > ib_s) ? W'(ib_s) :
                   ((ext(int_sat) < -ib_s) ? W'(-ib_s) : int_sat);
  assign lp_new = sat(ext(dlp) + ext(tmp));

  always_ff @(posedge clk) begin
    if (rst) begin
      op_run        <= 1'b0;
      m_axis_tvalid <= 1'b0;
      integ    <= '0;
      last_err <= '0;
      last_ms  <= '0;
      held     <= '0;
      t_p      <= '0;
      t_i      <= '0;
      t_d      <= '0;
      dlp      <= '0;
      pk_o     <= '0;
      pk_e     <= '0;
      primed   <= 1'b0;
    end else begin
      // the output state loads the next word itself
      if (m_axis_tvalid && m_axis_tready && state != pidc_pkg::ST_OUT)
        m_axis_tvalid <= 1'b0;
      if (mul_start || div_start) op_run <= 1'b1;
      if (mul_done || div_done)   op_run <= 1'b0;
      case (state)
        pidc_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            req_r <= s_axis_tuser;
            sp <= in_word(s_axis_tdata[31:0]);
            ms <= in_word(s_axis_tdata[63:32]);
            dt <= in_word(s_axis_tdata[95:64]);
          end
        end
        pidc_pkg::ST_DECODE: begin
          skip_r <= (req_r == pidc_pkg::REQ_UPDATE) && dt_bad;
          if (req_r == pidc_pkg::REQ_CLEAR) begin
            integ    <= '0;
            last_err <= '0;
            last_ms  <= '0;
            held     <= '0;
            t_p      <= '0;
            t_i      <= '0;
            t_d      <= '0;
            dlp      <= '0;
            pk_o     <= '0;
            pk_e     <= '0;
            primed   <= 1'b0;
          end
        end
        pidc_pkg::ST_ERR: begin
          err  <= sat(ext(sp) - ext(ms));
          mneg <= sp < ms;
        end
        pidc_pkg::ST_MUL_P: begin
          if (mul_done) t_p <= mq;
        end
        pidc_pkg::ST_MUL_E: begin
          if (mul_done) tmp <= mq;
        end
        pidc_pkg::ST_INT: begin
          integ <= int_new;
          mneg  <= int_new[W-1];
        end
        pidc_pkg::ST_MUL_I: begin
          if (mul_done) t_i <= mq;
        end
        pidc_pkg::ST_DSEL: begin
          if (!primed) begin
            t_d    <= '0;
            primed <= 1'b1;
          end else if (!d_mode) begin
            diff <= {err[W-1], err} - {last_err[W-1], last_err};
            dneg <= err < last_err;
          end else begin
            // derivative on the negated measurement
            diff <= {ms[W-1], ms} - {last_ms[W-1], last_ms};
            dneg <= ms > last_ms;
          end
        end
        pidc_pkg::ST_DIV: begin
          if (div_done) begin
            t_d  <= dq;
            diff <= {dq[W-1], dq} - {dlp[W-1], dlp};
            mneg <= dq < dlp;
          end
        end
        pidc_pkg::ST_MUL_LP: begin
          if (mul_done) tmp <= mq;
        end
        pidc_pkg::ST_LP: begin
          dlp <= lp_new;
          t_d <= lp_new;
        end
        pidc_pkg::ST_SUM: begin
          last_err <= err;
          last_ms  <= ms;
          tmp      <= sat(ext(t_p) + ext(t_i));
        end
        pidc_pkg::ST_OSUM: begin
          held <= o_w;
        end
        pidc_pkg::ST_PEAK: begin
          if (abs_s(held) > abs_s(pk_o)) pk_o <= held;
          if (abs_s(err) > abs_s(pk_e))  pk_e <= err;
        end
        pidc_pkg::ST_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {to_io(pk_e), to_io(pk_o), to_io(t_d), to_io(t_i),
                              to_io(t_p), to_io(held)};
            m_axis_tuser  <= skip_r;
            // read request hands out the peaks, then restarts them
            if (req_r == pidc_pkg::REQ_READ) begin
              pk_o <= '0;
              pk_e <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
